@@ rtl/core/uls_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 line sanitizer package
// Shared types, constants and byte classification helpers.
// ----------------------------------------------------------------------------
package uls_pkg;

  // Most result bytes one input byte can cause
  localparam int unsigned MaxOut   = 4;
  localparam int unsigned CntW     = $clog2(MaxOut + 1);
  localparam int unsigned IdxW     = $clog2(MaxOut);

  // Job queue between front and back part
  localparam int unsigned JobDepth = 2;
  localparam int unsigned JobPtrW  = $clog2(JobDepth);
  localparam int unsigned JobCntW  = $clog2(JobDepth + 1);

  localparam logic [7:0] ByteCr    = 8'h0D;
  localparam logic [7:0] ByteLf    = 8'h0A;

  // Result bytes caused by one accepted input byte
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [CntW-1:0]        cnt;
  } job_t;

  // Sequence length a byte announces: 1 ASCII, 2..4 lead, 0 otherwise
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    if ((c & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((c & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((c & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else if ((c & 8'h80) == 8'h00) begin
      len = 3'd1;
    end
    return len;
  endfunction

  function automatic logic is_crlf(input logic [7:0] c);
    return (c == ByteCr) || (c == ByteLf);
  endfunction

  // Plain ASCII byte that survives on its own
  function automatic logic keep_single(input logic [7:0] c);
    return !is_crlf(c) && (lead_len(c) == 3'd1);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/uls_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 line sanitizer front part
// Accepts bytes, tracks the open sequence and queues at most one job per byte.
// ----------------------------------------------------------------------------
module uls_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire logic [7:0]    data_byte_i,
  input  wire logic          line_end_i,
  output uls_pkg::job_t      job_o,
  output logic               job_push_o
);

  logic [2:0]       seq_len_q, seq_len_d;
  logic [1:0]       held_cnt_q, held_cnt_d;
  logic [2:0][7:0]  held_q, held_d;
  uls_pkg::job_t    job;
  logic [7:0]       x_byte;
  logic             x_keep, y_keep, complete;

  assign x_byte   = held_q[1];
  assign x_keep   = uls_pkg::keep_single(x_byte);
  assign y_keep   = uls_pkg::keep_single(data_byte_i);
  assign complete = ({1'b0, held_cnt_q} + 3'd1) >= seq_len_q;

  always_comb begin
    seq_len_d  = seq_len_q;
    held_cnt_d = held_cnt_q;
    held_d     = held_q;
    job.bytes  = '0;
    job.cnt    = '0;
    if (seq_len_q == 3'd0) begin
      if (!uls_pkg::is_crlf(data_byte_i)) begin
        if (uls_pkg::lead_len(data_byte_i) == 3'd1) begin
          job.bytes[0] = data_byte_i;
          job.cnt      = uls_pkg::CntW'(1);
        end else if (uls_pkg::lead_len(data_byte_i) >= 3'd2 && !line_end_i) begin
          held_d[0]  = data_byte_i;
          held_cnt_d = 2'd1;
          seq_len_d  = uls_pkg::lead_len(data_byte_i);
        end
      end
    end else if (complete) begin
      // emit held bytes with the new byte right after them
      for (int j = 0; j < 3; j++) begin
        job.bytes[j] = (2'(j) == held_cnt_q) ? data_byte_i : held_q[j];
      end
      job.bytes[3] = data_byte_i;
      job.cnt      = uls_pkg::CntW'(held_cnt_q) + uls_pkg::CntW'(1);
      seq_len_d    = 3'd0;
      held_cnt_d   = 2'd0;
    end else if (!line_end_i) begin
      held_d[held_cnt_q] = data_byte_i;
      held_cnt_d         = held_cnt_q + 2'd1;
    end else begin
      // line ended early: drop the lead, rescan what follows it
      seq_len_d  = 3'd0;
      held_cnt_d = 2'd0;
      if (held_cnt_q == 2'd2 && uls_pkg::lead_len(x_byte) == 3'd2) begin
        job.bytes[0] = x_byte;
        job.bytes[1] = data_byte_i;
        job.cnt      = uls_pkg::CntW'(2);
      end else if (held_cnt_q == 2'd2 && x_keep) begin
        job.bytes[0] = x_byte;
        job.bytes[1] = data_byte_i;
        job.cnt      = y_keep ? uls_pkg::CntW'(2) : uls_pkg::CntW'(1);
      end else if (y_keep) begin
        job.bytes[0] = data_byte_i;
        job.cnt      = uls_pkg::CntW'(1);
      end
    end
  end

  assign job_o      = job;
  assign job_push_o = fire_i && (job.cnt != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q  <= 3'd0;
      held_cnt_q <= 2'd0;
    end else if (fire_i) begin
      seq_len_q  <= seq_len_d;
      held_cnt_q <= held_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      held_q <= held_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/uls_job_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 line sanitizer job queue
// Short queue of jobs that decouples the front part from the back part.
// ----------------------------------------------------------------------------
module uls_job_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire uls_pkg::job_t job_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output uls_pkg::job_t      job_o,
  output logic               valid_o
);

  uls_pkg::job_t                      mem_q [uls_pkg::JobDepth];
  logic [uls_pkg::JobPtrW-1:0]        wptr_q, rptr_q;
  logic [uls_pkg::JobCntW-1:0]        cnt_q, cnt_d;
  logic                               do_push, do_pop;

  assign full_o  = (cnt_q == uls_pkg::JobCntW'(uls_pkg::JobDepth));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rptr_q];

  function automatic logic [uls_pkg::JobPtrW-1:0] nxt(
    input logic [uls_pkg::JobPtrW-1:0] p);
    logic [uls_pkg::JobPtrW-1:0] n;
    n = p + 1'b1;
    if (p == uls_pkg::JobPtrW'(uls_pkg::JobDepth - 1)) begin
      n = '0;
    end
    return n;
  endfunction

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= nxt(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= nxt(rptr_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/uls_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 line sanitizer back part
// Walks the head job byte by byte into the registered result stage.
// ----------------------------------------------------------------------------
module uls_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire uls_pkg::job_t job_i,
  input  wire logic          job_valid_i,
  output logic               job_pop_o,
  input  wire logic          pop,
  output logic               empty,
  output logic [7:0]         out_byte_o,
  output logic               last_of_run_o
);

  logic [uls_pkg::IdxW-1:0] idx_q, idx_d;
  logic                     ovalid_q, ovalid_d;
  logic [7:0]               obyte_q;
  logic                     olast_q;
  logic                     load, is_last;

  assign is_last   = (uls_pkg::CntW'(idx_q) == job_i.cnt - uls_pkg::CntW'(1));
  // result stage frees up when empty or being taken this cycle
  assign load      = job_valid_i && (!ovalid_q || pop);
  assign job_pop_o = load && is_last;

  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    if (pop && ovalid_q) begin
      ovalid_d = 1'b0;
    end
    if (load) begin
      ovalid_d = 1'b1;
      idx_d    = is_last ? '0 : idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      obyte_q <= job_i.bytes[idx_q];
      olast_q <= is_last;
    end
  end

  assign empty         = !ovalid_q;
  assign out_byte_o    = obyte_q;
  assign last_of_run_o = olast_q;

endmodule
`default_nettype wire

@@ rtl/core/utf8_line_sanitizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 line sanitizer
// Drops line breaks, stray bytes and cut-short sequences from a byte stream.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while full is low. Each byte becomes a job of
// zero to four result bytes; jobs wait in a two-entry queue and the back part
// sends one result byte per cycle while pop is high or the result register
// is empty, so new bytes can be taken while earlier results still wait. full
// rises while two jobs wait. A result passes through the job queue, then the
// result register, after the edge that accepts its request. last_of_run_o
// marks the final result caused by one input byte.
module utf8_line_sanitizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        line_end_i,
  input  wire logic        pop,
  output logic             empty,
  output logic [7:0]       out_byte_o,
  output logic             last_of_run_o
);

  uls_pkg::job_t front_job, head_job;
  logic          front_push, fire, head_valid, head_pop;

  assign fire = push && !full;

  uls_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .data_byte_i (data_byte_i),
    .line_end_i  (line_end_i),
    .job_o       (front_job),
    .job_push_o  (front_push)
  );

  uls_job_fifo u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .job_i   (front_job),
    .full_o  (full),
    .pop_i   (head_pop),
    .job_o   (head_job),
    .valid_o (head_valid)
  );

  uls_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head_job),
    .job_valid_i   (head_valid),
    .job_pop_o     (head_pop),
    .pop           (pop),
    .empty         (empty),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
`default_nettype wire

@@ rtl/core/uls_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// UTF-8 line sanitizer checker
// Port-level checks on reset behavior and result delivery.
// ----------------------------------------------------------------------------
module uls_port_checks (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        full,
  input  wire logic        pop,
  input  wire logic        empty,
  input  wire logic [7:0]  out_byte_o,
  input  wire logic        last_of_run_o
);

  // nothing waits right after reset
  a_empty_after_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> empty)
    else $error("result shown right after reset");

  a_room_after_reset: assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !full)
    else $error("full right after reset");

  // a run is delivered without gaps once started
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !last_of_run_o) |=> !empty)
    else $error("gap inside a run of results");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(last_of_run_o)))
    else $error("waiting result changed");

endmodule

bind utf8_line_sanitizer uls_port_checks u_uls_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .full          (full),
  .pop           (pop),
  .empty         (empty),
  .out_byte_o    (out_byte_o),
  .last_of_run_o (last_of_run_o)
);
`default_nettype wire
